@@ rtl/core/fsc_pkg.sv @@
`default_nettype none

package fsc_pkg;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int TRIG_W   = 16;
   localparam int MODE_W   = 5;
   localparam int SCALE_W  = 17;
   localparam int SUM_W    = 48;
   localparam int COEFF_W  = 32;
   localparam int PROD_W   = SAMPLE_W + TRIG_W;
   localparam int ROT_W    = 2 * TRIG_W;

   // register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SCALE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 1'b1;

   // mode storage never needs more entries than the mode index can name
   localparam int MODE_LIMIT    = 2 ** MODE_W;
   localparam int MAX_MODES_DEF = 32;

   localparam logic [MODE_W-1:0]  MODE_COUNT_RESET   = '0;
   localparam logic [SCALE_W-1:0] SCALE_FACTOR_RESET = SCALE_W'(65536);
   localparam logic signed [TRIG_W-1:0] TRIG_ONE     = TRIG_W'(16384);

   // sequencer strobes shared by the datapath units
   typedef struct packed {
      logic              init;    // start of a sample: rotation back to mode 0
      logic              mul;     // products registered, sums read
      logic              step;    // rotation advanced, sums written back
      logic              out_rd;  // sums read for a result word
      logic              mag;     // magnitude of the sums registered
      logic              omul;    // scaling partial products registered
      logic              clear;   // all sums back to zero
      logic [MODE_W-1:0] mode;    // current mode
   } fsc_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/fsc_rotor.sv @@
`default_nettype none

module fsc_rotor (
   input  wire                                     clock,
   input  wire fsc_pkg::fsc_ctl_type               ctl,
   input  wire logic signed [fsc_pkg::TRIG_W-1:0]  cos_azimuth,
   input  wire logic signed [fsc_pkg::TRIG_W-1:0]  sin_azimuth,
   output logic signed [fsc_pkg::TRIG_W-1:0]       cos_term,
   output logic signed [fsc_pkg::TRIG_W-1:0]       sin_term
);

   localparam int RQ_W = fsc_pkg::ROT_W + 2 - 14;

   logic signed [fsc_pkg::TRIG_W-1:0] c_ff, c_in, s_ff, s_in;
   logic signed [fsc_pkg::ROT_W-1:0]  p_cc_ff, p_cc_in, p_ss_ff, p_ss_in;
   logic signed [fsc_pkg::ROT_W-1:0]  p_sc_ff, p_sc_in, p_cs_ff, p_cs_in;
   logic signed [fsc_pkg::ROT_W:0]    cos_sum, sin_sum;

   // round half up at q14 and clamp to 16 bits
   function automatic logic signed [fsc_pkg::TRIG_W-1:0] rot_round(
      input logic signed [fsc_pkg::ROT_W:0] x);
      logic signed [fsc_pkg::ROT_W+1:0] b;
      logic signed [RQ_W-1:0]           q;
      b = (fsc_pkg::ROT_W+2)'(x) + (fsc_pkg::ROT_W+2)'(8192);
      q = b[fsc_pkg::ROT_W+1:14];
      if (q > RQ_W'(32767)) begin
         rot_round = fsc_pkg::TRIG_W'(32767);
      end else if (q < RQ_W'(-32768)) begin
         rot_round = fsc_pkg::TRIG_W'(-32768);
      end else begin
         rot_round = q[fsc_pkg::TRIG_W-1:0];
      end
   endfunction

   // angle addition from the registered products
   assign cos_sum = (fsc_pkg::ROT_W+1)'(p_cc_ff) - (fsc_pkg::ROT_W+1)'(p_ss_ff);
   assign sin_sum = (fsc_pkg::ROT_W+1)'(p_sc_ff) + (fsc_pkg::ROT_W+1)'(p_cs_ff);

   always_comb begin
      c_in    = c_ff;
      s_in    = s_ff;
      p_cc_in = p_cc_ff;
      p_ss_in = p_ss_ff;
      p_sc_in = p_sc_ff;
      p_cs_in = p_cs_ff;
      if (ctl.init) begin
         c_in = fsc_pkg::TRIG_ONE;
         s_in = '0;
      end else if (ctl.step) begin
         c_in = rot_round(cos_sum);
         s_in = rot_round(sin_sum);
      end
      if (ctl.mul) begin
         p_cc_in = c_ff * cos_azimuth;
         p_ss_in = s_ff * sin_azimuth;
         p_sc_in = s_ff * cos_azimuth;
         p_cs_in = c_ff * sin_azimuth;
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      s_ff    <= s_in;
      p_cc_ff <= p_cc_in;
      p_ss_ff <= p_ss_in;
      p_sc_ff <= p_sc_in;
      p_cs_ff <= p_cs_in;
   end

   assign cos_term = c_ff;
   assign sin_term = s_ff;

endmodule

`default_nettype wire

@@ rtl/core/fsc_sum_mem.sv @@
`default_nettype none

module fsc_sum_mem #(
   parameter int MAX_MODES = fsc_pkg::MAX_MODES_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire fsc_pkg::fsc_ctl_type                 ctl,
   input  wire logic signed [fsc_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic signed [fsc_pkg::TRIG_W-1:0]    cos_term,
   input  wire logic signed [fsc_pkg::TRIG_W-1:0]    sin_term,
   output logic signed [fsc_pkg::SUM_W-1:0]          rd_cos,
   output logic signed [fsc_pkg::SUM_W-1:0]          rd_sin
);

   localparam int DEPTH = (MAX_MODES < fsc_pkg::MODE_LIMIT) ? MAX_MODES : fsc_pkg::MODE_LIMIT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [fsc_pkg::SUM_W-1:0]  cos_mem_ff [DEPTH];
   logic signed [fsc_pkg::SUM_W-1:0]  sin_mem_ff [DEPTH];
   logic signed [fsc_pkg::SUM_W-1:0]  rd_cos_q_ff, rd_sin_q_ff;
   logic [DEPTH-1:0]                  valid_ff, valid_in;
   logic                              rvalid_ff;
   logic [AW-1:0]                     addr, addr_ff;
   logic signed [fsc_pkg::PROD_W-1:0] pm_c_ff, pm_c_in, pm_s_ff, pm_s_in;
   logic signed [fsc_pkg::SUM_W-1:0]  new_cos, new_sin;

   // add with clamp to the 48-bit range
   function automatic logic signed [fsc_pkg::SUM_W-1:0] sat_add(
      input logic signed [fsc_pkg::SUM_W-1:0]  a,
      input logic signed [fsc_pkg::PROD_W-1:0] b);
      logic signed [fsc_pkg::SUM_W:0] t;
      t = (fsc_pkg::SUM_W+1)'(a) + (fsc_pkg::SUM_W+1)'(b);
      if (t[fsc_pkg::SUM_W] != t[fsc_pkg::SUM_W-1]) begin
         sat_add = t[fsc_pkg::SUM_W] ? {1'b1, {(fsc_pkg::SUM_W-1){1'b0}}}
                                     : {1'b0, {(fsc_pkg::SUM_W-1){1'b1}}};
      end else begin
         sat_add = t[fsc_pkg::SUM_W-1:0];
      end
   endfunction

   assign addr = ctl.mode[AW-1:0];

   // entries never written since the last clear read as zero
   assign rd_cos = rvalid_ff ? rd_cos_q_ff : '0;
   assign rd_sin = rvalid_ff ? rd_sin_q_ff : '0;

   assign new_cos = sat_add(rd_cos, pm_c_ff);
   assign new_sin = sat_add(rd_sin, pm_s_ff);

   always_comb begin
      pm_c_in  = pm_c_ff;
      pm_s_in  = pm_s_ff;
      valid_in = valid_ff;
      if (ctl.mul) begin
         pm_c_in = sample * cos_term;
         pm_s_in = sample * sin_term;
      end
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.step) begin
         valid_in[addr_ff] = 1'b1;
      end
   end

   // sum storage, one read and one write port
   always_ff @(posedge clock) begin
      if (ctl.mul || ctl.out_rd) begin
         rd_cos_q_ff <= cos_mem_ff[addr];
         rd_sin_q_ff <= sin_mem_ff[addr];
         rvalid_ff   <= valid_ff[addr];
         addr_ff     <= addr;
      end
      if (ctl.step) begin
         cos_mem_ff[addr_ff] <= new_cos;
         sin_mem_ff[addr_ff] <= new_sin;
      end
   end

   always_ff @(posedge clock) begin
      pm_c_ff <= pm_c_in;
      pm_s_ff <= pm_s_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/fsc_scaler.sv @@
`default_nettype none

module fsc_scaler (
   input  wire                                      clock,
   input  wire fsc_pkg::fsc_ctl_type                ctl,
   input  wire logic [fsc_pkg::SCALE_W-1:0]         scale_factor,
   input  wire logic signed [fsc_pkg::SUM_W-1:0]    rd_cos,
   input  wire logic signed [fsc_pkg::SUM_W-1:0]    rd_sin,
   output logic signed [fsc_pkg::COEFF_W-1:0]       cos_coeff,
   output logic signed [fsc_pkg::COEFF_W-1:0]       sin_coeff
);

   localparam int HALF_W = fsc_pkg::SUM_W / 2;
   localparam int PP_W   = HALF_W + fsc_pkg::SCALE_W;
   localparam int TOT_W  = PP_W + HALF_W + 1;
   localparam int Q_W    = TOT_W - 30;

   logic                          neg_c_ff, neg_c_in, neg_s_ff, neg_s_in;
   logic [fsc_pkg::SUM_W-1:0]     mag_c_ff, mag_c_in, mag_s_ff, mag_s_in;
   logic [PP_W-1:0]               ph_c_ff, ph_c_in, pl_c_ff, pl_c_in;
   logic [PP_W-1:0]               ph_s_ff, ph_s_in, pl_s_ff, pl_s_in;

   // combine partial products, round half away from zero, clamp to 32 bits
   function automatic logic signed [fsc_pkg::COEFF_W-1:0] finish(
      input logic neg, input logic [PP_W-1:0] ph, input logic [PP_W-1:0] pl);
      logic [TOT_W-1:0] tot;
      logic [Q_W-1:0]   q;
      tot = {ph, {HALF_W{1'b0}}} + TOT_W'(pl) + (TOT_W'(1) << 29);
      q   = tot[TOT_W-1:30];
      if (neg) begin
         if (q > (Q_W'(1) << 31)) begin
            finish = {1'b1, {(fsc_pkg::COEFF_W-1){1'b0}}};
         end else begin
            finish = -q[fsc_pkg::COEFF_W-1:0];
         end
      end else begin
         if (q > Q_W'(32'h7fff_ffff)) begin
            finish = {1'b0, {(fsc_pkg::COEFF_W-1){1'b1}}};
         end else begin
            finish = q[fsc_pkg::COEFF_W-1:0];
         end
      end
   endfunction

   always_comb begin
      neg_c_in = neg_c_ff;
      neg_s_in = neg_s_ff;
      mag_c_in = mag_c_ff;
      mag_s_in = mag_s_ff;
      ph_c_in  = ph_c_ff;
      pl_c_in  = pl_c_ff;
      ph_s_in  = ph_s_ff;
      pl_s_in  = pl_s_ff;
      // sign and magnitude
      if (ctl.mag) begin
         neg_c_in = rd_cos[fsc_pkg::SUM_W-1];
         neg_s_in = rd_sin[fsc_pkg::SUM_W-1];
         mag_c_in = neg_c_in ? fsc_pkg::SUM_W'(-rd_cos) : fsc_pkg::SUM_W'(rd_cos);
         mag_s_in = neg_s_in ? fsc_pkg::SUM_W'(-rd_sin) : fsc_pkg::SUM_W'(rd_sin);
      end
      // 24 x 17 partial products per half
      if (ctl.omul) begin
         ph_c_in = mag_c_ff[fsc_pkg::SUM_W-1:HALF_W] * scale_factor;
         pl_c_in = mag_c_ff[HALF_W-1:0] * scale_factor;
         ph_s_in = mag_s_ff[fsc_pkg::SUM_W-1:HALF_W] * scale_factor;
         pl_s_in = mag_s_ff[HALF_W-1:0] * scale_factor;
      end
   end

   always_ff @(posedge clock) begin
      neg_c_ff <= neg_c_in;
      neg_s_ff <= neg_s_in;
      mag_c_ff <= mag_c_in;
      mag_s_ff <= mag_s_in;
      ph_c_ff  <= ph_c_in;
      pl_c_ff  <= pl_c_in;
      ph_s_ff  <= ph_s_in;
      pl_s_ff  <= pl_s_in;
   end

   assign cos_coeff = finish(neg_c_ff, ph_c_ff, pl_c_ff);
   assign sin_coeff = finish(neg_s_ff, ph_s_ff, pl_s_ff);

endmodule

`default_nettype wire

@@ rtl/core/fourier_series_coefficients.sv @@
// Fourier series coefficients of one azimuthally sampled function.
// Input words carry a 24-bit sample with the Q2.14 cosine and sine of its
// azimuth; req_last_sample closes the set. Each word is accepted when
// req_valid is high and req_stall low. For modes 0 to mode_count, capped
// at MAX_MODES-1, the block rotates cos/sin by angle addition and adds
// sample times each term into per-mode 48-bit sums held in a small memory.
// Each mode passes a multiply step and a rotate step on the shared rotate
// and multiply unit; req_stall stays high until the mode walk is done.
// On the last sample one result word per mode follows, mode 0 first;
// each passes sum read, magnitude, partial products, round and clamp, and
// req_stall stays high until the last result word is issued.
// The sums are then cleared together through per-entry valid flags.
// Results sit in an output register: while rsp_stall is high the word is
// held and the block waits; the next input word is taken while the final
// result still waits. Reset clears the sums, sets mode_count to 0 and
// scale_factor to 1.0, and drops rsp_valid. csr_we writes a register.
`default_nettype none

module fourier_series_coefficients #(
   parameter int MAX_MODES = fsc_pkg::MAX_MODES_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire logic signed [fsc_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic signed [fsc_pkg::TRIG_W-1:0]    req_cos_azimuth,
   input  wire logic signed [fsc_pkg::TRIG_W-1:0]    req_sin_azimuth,
   input  wire                                       req_last_sample,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic [fsc_pkg::MODE_W-1:0]                rsp_mode_index,
   output logic signed [fsc_pkg::COEFF_W-1:0]        rsp_cos_coeff,
   output logic signed [fsc_pkg::COEFF_W-1:0]        rsp_sin_coeff,
   output logic                                      rsp_last_mode,
   input  wire                                       csr_we,
   input  wire logic [fsc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [fsc_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int DEPTH = (MAX_MODES < fsc_pkg::MODE_LIMIT) ? MAX_MODES : fsc_pkg::MODE_LIMIT;
   localparam logic [fsc_pkg::MODE_W-1:0] TOP_LIMIT = fsc_pkg::MODE_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC_MUL,
      ST_ACC_STEP,
      ST_O_RD,
      ST_O_MAG,
      ST_O_MUL,
      ST_O_FIN
   } state_type;

   state_type                           state_ff, state_in;
   logic [fsc_pkg::MODE_W-1:0]          mode_count_ff, mode_count_in;
   logic [fsc_pkg::SCALE_W-1:0]         scale_factor_ff, scale_factor_in;
   logic signed [fsc_pkg::SAMPLE_W-1:0] smp_ff, smp_in;
   logic signed [fsc_pkg::TRIG_W-1:0]   cx_ff, cx_in, sx_ff, sx_in;
   logic                                last_ff, last_in;
   logic [fsc_pkg::MODE_W-1:0]          top_ff, top_in, mode_ff, mode_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fsc_pkg::MODE_W-1:0]          rsp_mode_ff, rsp_mode_in;
   logic signed [fsc_pkg::COEFF_W-1:0]  rsp_cos_ff, rsp_cos_in, rsp_sin_ff, rsp_sin_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                accept, out_free;
   fsc_pkg::fsc_ctl_type                ctl;
   logic signed [fsc_pkg::TRIG_W-1:0]   cos_term, sin_term;
   logic signed [fsc_pkg::SUM_W-1:0]    rd_cos, rd_sin;
   logic signed [fsc_pkg::COEFF_W-1:0]  cos_coeff, sin_coeff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      mode_count_in   = mode_count_ff;
      scale_factor_in = scale_factor_ff;
      smp_in          = smp_ff;
      cx_in           = cx_ff;
      sx_in           = sx_ff;
      last_in         = last_ff;
      top_in          = top_ff;
      mode_in         = mode_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_mode_in     = rsp_mode_ff;
      rsp_cos_in      = rsp_cos_ff;
      rsp_sin_in      = rsp_sin_ff;
      rsp_last_in     = rsp_last_ff;
      ctl             = '0;
      ctl.mode        = mode_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            fsc_pkg::CSR_MODE_COUNT: begin
               mode_count_in = csr_data[fsc_pkg::MODE_W-1:0];
            end
            fsc_pkg::CSR_SCALE_FACTOR: begin
               scale_factor_in = csr_data[fsc_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               smp_in   = req_sample;
               cx_in    = req_cos_azimuth;
               sx_in    = req_sin_azimuth;
               last_in  = req_last_sample;
               top_in   = (mode_count_ff > TOP_LIMIT) ? TOP_LIMIT : mode_count_ff;
               mode_in  = '0;
               ctl.init = 1'b1;
               state_in = ST_ACC_MUL;
            end
         end
         ST_ACC_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_ACC_STEP;
         end
         ST_ACC_STEP: begin
            ctl.step = 1'b1;
            if (mode_ff == top_ff) begin
               mode_in  = '0;
               state_in = last_ff ? ST_O_RD : ST_IDLE;
            end else begin
               mode_in  = mode_ff + 1'b1;
               state_in = ST_ACC_MUL;
            end
         end
         ST_O_RD: begin
            ctl.out_rd = 1'b1;
            state_in   = ST_O_MAG;
         end
         ST_O_MAG: begin
            ctl.mag  = 1'b1;
            state_in = ST_O_MUL;
         end
         ST_O_MUL: begin
            ctl.omul = 1'b1;
            state_in = ST_O_FIN;
         end
         ST_O_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mode_in  = mode_ff;
               rsp_cos_in   = cos_coeff;
               rsp_sin_in   = sin_coeff;
               rsp_last_in  = (mode_ff == top_ff);
               if (mode_ff == top_ff) begin
                  ctl.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  mode_in  = mode_ff + 1'b1;
                  state_in = ST_O_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      cx_ff       <= cx_in;
      sx_ff       <= sx_in;
      last_ff     <= last_in;
      top_ff      <= top_in;
      mode_ff     <= mode_in;
      rsp_mode_ff <= rsp_mode_in;
      rsp_cos_ff  <= rsp_cos_in;
      rsp_sin_ff  <= rsp_sin_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_count_ff   <= fsc_pkg::MODE_COUNT_RESET;
         scale_factor_ff <= fsc_pkg::SCALE_FACTOR_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_count_ff   <= mode_count_in;
         scale_factor_ff <= scale_factor_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // shared rotation unit
   fsc_rotor u_rotor (
      .clock       (clock),
      .ctl         (ctl),
      .cos_azimuth (cx_ff),
      .sin_azimuth (sx_ff),
      .cos_term    (cos_term),
      .sin_term    (sin_term)
   );

   // per-mode sums
   fsc_sum_mem #(
      .MAX_MODES (MAX_MODES)
   ) u_sum_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample   (smp_ff),
      .cos_term (cos_term),
      .sin_term (sin_term),
      .rd_cos   (rd_cos),
      .rd_sin   (rd_sin)
   );

   // output scaling
   fsc_scaler u_scaler (
      .clock        (clock),
      .ctl          (ctl),
      .scale_factor (scale_factor_ff),
      .rd_cos       (rd_cos),
      .rd_sin       (rd_sin),
      .cos_coeff    (cos_coeff),
      .sin_coeff    (sin_coeff)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mode_index = rsp_mode_ff;
   assign rsp_cos_coeff  = rsp_cos_ff;
   assign rsp_sin_coeff  = rsp_sin_ff;
   assign rsp_last_mode  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // an accepted word always starts the accumulation walk
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ACC_MUL)
      else $error("accepted word did not start accumulation");

   // the mode walk never passes the highest mode of the word
   a_mode_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> mode_ff <= top_ff)
      else $error("mode counter beyond highest mode");

   // a pending result that is not the last keeps the block busy
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_mode |-> state_ff != ST_IDLE)
      else $error("block idle before the last result word");

   // partial products are always followed by the finishing step
   a_mul_then_fin: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_O_MUL |=> state_ff == ST_O_FIN)
      else $error("scaling pipeline out of step");
`endif

endmodule

`default_nettype wire
